// ===== design/boxavg_pkg.sv =====
// Shared types and constants for the box-average image downscaler.
// Holds field widths, register reset values, register indexes and flag structs.
// No dependencies.
package boxavg_pkg;

    // Pixel and stream field widths.
    localparam int PIX_W   = 16;
    localparam int NUM_CH  = 3;
    localparam int DATA_W  = PIX_W * NUM_CH;

    // Configuration register widths and port widths.
    localparam int SCALE_W    = 4;
    localparam int WIDTH_W    = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Defaults for the size parameters of the top level.
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_SCALE = 8;

    // Register values after reset.
    localparam logic [SCALE_W-1:0] RST_SCALE = SCALE_W'(1);
    localparam logic [WIDTH_W-1:0] RST_WIDTH = WIDTH_W'(4096);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FACTOR = 8'd0,
        REG_IMAGE_WIDTH  = 8'd1
    } cfg_reg_t;

    // Per-pixel position flags handed from the position tracker to the accumulator.
    typedef struct packed {
        logic first;    // first pixel of its block: overwrite the running sum
        logic last;     // last pixel of its block: the block mean is due
        logic fits;     // the pixel lies in a complete block of the row
        logic row_end;  // the block is the last complete block of its row
    } pos_flags_t;

endpackage

// ===== design/boxavg_pos.sv =====
// Position tracker of the box-average downscaler: configuration registers,
// raster counters and per-pixel block flags. Depends on boxavg_pkg.
module boxavg_pos
    import boxavg_pkg::*;
#(
    parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter  int MAX_SCALE = DEF_MAX_SCALE,
    localparam int AW        = $clog2(MAX_WIDTH),
    localparam int SW        = $clog2(MAX_SCALE + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  sof,
    output logic [AW-1:0]         addr,
    output pos_flags_t            flags,
    output logic [SW-1:0]         scale_eff
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int BW  = $clog2(MAX_SCALE);
    localparam int SXW = ((SW > SCALE_W) ? SW : SCALE_W) + 1;
    localparam int WXW = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [AW-1:0]      cp_reg, cp_next;
    logic [BW-1:0]      rib_reg, rib_next;
    logic [BW-1:0]      cib_reg, cib_next;
    logic [AW-1:0]      oc_reg, oc_next;

    logic [CW-1:0]      width_eff;
    logic [AW-1:0]      cp_cur;
    logic [BW-1:0]      rib_cur;
    logic [BW-1:0]      cib_cur;
    logic [AW-1:0]      oc_cur;
    logic [CW:0]        block_last_col;
    logic [CW:0]        next_block_end;
    logic [SW-1:0]      cib_inc;
    logic [SW-1:0]      rib_inc;
    logic [CW-1:0]      cp_inc;
    logic               cfg_hit;

    // Out-of-range register values are clamped.
    always_comb
    begin
        if (scale_reg == '0)
            scale_eff = SW'(1);
        else if (SXW'(scale_reg) > SXW'(MAX_SCALE))
            scale_eff = SW'(MAX_SCALE);
        else
            scale_eff = SW'(scale_reg);

        if (width_reg == '0)
            width_eff = CW'(1);
        else if (WXW'(width_reg) > WXW'(MAX_WIDTH))
            width_eff = CW'(MAX_WIDTH);
        else
            width_eff = CW'(width_reg);
    end

    // A start-of-frame pixel is placed as if the counters were already clear.
    assign cp_cur  = sof ? '0 : cp_reg;
    assign rib_cur = sof ? '0 : rib_reg;
    assign cib_cur = sof ? '0 : cib_reg;
    assign oc_cur  = sof ? '0 : oc_reg;

    // The block fits when its last column lies inside the row.
    assign block_last_col = (CW + 1)'(cp_cur) + (CW + 1)'(scale_eff)
                          - (CW + 1)'(1) - (CW + 1)'(cib_cur);
    assign next_block_end = (CW + 1)'(cp_cur) + (CW + 1)'(scale_eff);

    always_comb
    begin
        flags.first   = (rib_cur == '0) && (cib_cur == '0);
        flags.last    = (SW'(rib_cur) == scale_eff - SW'(1))
                     && (SW'(cib_cur) == scale_eff - SW'(1));
        flags.fits    = block_last_col < (CW + 1)'(width_eff);
        // Only consulted on a block's last pixel, where the next block would
        // end s columns further on.
        flags.row_end = next_block_end >= (CW + 1)'(width_eff);
    end

    assign addr = oc_cur;

    always_comb
    begin
        cib_inc  = SW'(cib_cur) + SW'(1);
        rib_inc  = SW'(rib_cur) + SW'(1);
        cp_inc   = CW'(cp_cur) + CW'(1);
        cib_next = cib_reg;
        rib_next = rib_reg;
        cp_next  = cp_reg;
        oc_next  = oc_reg;
        if (accept)
        begin
            if (cib_inc >= scale_eff)
            begin
                cib_next = '0;
                oc_next  = oc_cur + AW'(1);
            end
            else
            begin
                cib_next = BW'(cib_inc);
                oc_next  = oc_cur;
            end
            rib_next = rib_cur;
            cp_next  = AW'(cp_inc);
            if (cp_inc >= width_eff)
            begin
                cp_next  = '0;
                cib_next = '0;
                oc_next  = '0;
                rib_next = (rib_inc >= scale_eff) ? '0 : BW'(rib_inc);
            end
        end
    end

    assign cfg_hit = cfg_write
                  && ((cfg_index == REG_SCALE_FACTOR) || (cfg_index == REG_IMAGE_WIDTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= RST_SCALE;
            width_reg <= RST_WIDTH;
            cp_reg    <= '0;
            rib_reg   <= '0;
            cib_reg   <= '0;
            oc_reg    <= '0;
        end
        else if (cfg_hit)
        begin
            // Any valid register write starts a new frame.
            unique case (cfg_index)
                REG_SCALE_FACTOR: scale_reg <= cfg_data[SCALE_W-1:0];
                REG_IMAGE_WIDTH:  width_reg <= cfg_data[WIDTH_W-1:0];
                default:          scale_reg <= scale_reg;
            endcase
            cp_reg  <= '0;
            rib_reg <= '0;
            cib_reg <= '0;
            oc_reg  <= '0;
        end
        else
        begin
            cp_reg  <= cp_next;
            rib_reg <= rib_next;
            cib_reg <= cib_next;
            oc_reg  <= oc_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) SW'(cib_reg) < scale_eff)
        else $error("column within block reached the scale factor");

    assert property (@(posedge clk) disable iff (!rst_n) SW'(rib_reg) < scale_eff)
        else $error("row within block reached the scale factor");

    assert property (@(posedge clk) disable iff (!rst_n) CW'(cp_reg) < width_eff)
        else $error("column position reached the image width");

endmodule

// ===== design/boxavg_accum.sv =====
// Column-sum line of the box-average downscaler: one synchronous memory entry
// per output column, updated by read-modify-write with a write bypass. Depends on boxavg_pkg.
module boxavg_accum
    import boxavg_pkg::*;
#(
    parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter  int MAX_SCALE = DEF_MAX_SCALE,
    localparam int AW        = $clog2(MAX_WIDTH),
    localparam int SUM_W     = PIX_W + 2 * $clog2(MAX_SCALE)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    output logic              ready,
    input  logic [DATA_W-1:0] pixel,
    input  logic [AW-1:0]     addr,
    input  pos_flags_t        flags,
    output logic              sum_valid,
    input  logic              sum_ready,
    output logic [SUM_W-1:0]  sum_red,
    output logic [SUM_W-1:0]  sum_green,
    output logic [SUM_W-1:0]  sum_blue,
    output logic              sum_row_end
);

    localparam int LINE_W = NUM_CH * SUM_W;

    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    logic              s1_valid_reg, s1_valid_next;
    logic [AW-1:0]     s1_addr_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic              s1_row_end_reg;
    logic [DATA_W-1:0] s1_pix_reg;

    logic              byp_valid_reg;
    logic [AW-1:0]     byp_addr_reg;
    logic [LINE_W-1:0] byp_data_reg;

    logic              load;
    logic              s1_go;
    logic [LINE_W-1:0] old_sums;
    logic [LINE_W-1:0] new_sums;

    assign load  = accept && flags.fits;
    assign s1_go = s1_valid_reg && (!s1_last_reg || sum_ready);
    assign ready = !s1_valid_reg || s1_go;

    // The latest write may have landed after this entry was read.
    assign old_sums = (byp_valid_reg && (byp_addr_reg == s1_addr_reg)) ? byp_data_reg
                                                                      : rd_data_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (s1_first_reg)
                new_sums[c*SUM_W +: SUM_W] = SUM_W'(s1_pix_reg[c*PIX_W +: PIX_W]);
            else
                new_sums[c*SUM_W +: SUM_W] = old_sums[c*SUM_W +: SUM_W]
                                           + SUM_W'(s1_pix_reg[c*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rd_data_reg <= line_mem[addr];
        if (s1_go)
            line_mem[s1_addr_reg] <= new_sums;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ready)
            s1_valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_go)
                byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            s1_addr_reg    <= addr;
            s1_first_reg   <= flags.first;
            s1_last_reg    <= flags.last;
            s1_row_end_reg <= flags.row_end;
            s1_pix_reg     <= pixel;
        end
        if (s1_go)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= new_sums;
        end
    end

    assign sum_valid   = s1_valid_reg && s1_last_reg;
    assign sum_red     = new_sums[0*SUM_W +: SUM_W];
    assign sum_green   = new_sums[1*SUM_W +: SUM_W];
    assign sum_blue    = new_sums[2*SUM_W +: SUM_W];
    assign sum_row_end = s1_row_end_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
                     s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("stalled sum update lost or changed its entry");

    assert property (@(posedge clk) disable iff (!rst_n)
                     accept && flags.fits |=> s1_valid_reg && (s1_addr_reg == $past(addr)))
        else $error("accepted pixel in a complete block did not reach the update stage");

    assert property (@(posedge clk) disable iff (!rst_n)
                     s1_go |=> byp_valid_reg && (byp_addr_reg == $past(s1_addr_reg)))
        else $error("bypass does not hold the latest written entry");

endmodule

// ===== design/boxavg_div.sv =====
// Mean stage of the box-average downscaler: divides block sums by the block
// area through a reciprocal multiply, then holds the result. Depends on boxavg_pkg.
module boxavg_div
    import boxavg_pkg::*;
#(
    parameter  int MAX_SCALE = DEF_MAX_SCALE,
    localparam int SUM_W     = PIX_W + 2 * $clog2(MAX_SCALE),
    localparam int SW        = $clog2(MAX_SCALE + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SUM_W-1:0]  sum_red,
    input  logic [SUM_W-1:0]  sum_green,
    input  logic [SUM_W-1:0]  sum_blue,
    input  logic              in_row_end,
    input  logic [SW-1:0]     scale,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,
    output logic              m_axis_tlast
);

    // With m = ceil(2^K / area) and K = SUM_W + 2*log2(MAX_SCALE), the product
    // shifted down by K is the exact truncated quotient for every sum.
    localparam int LOG_S  = $clog2(MAX_SCALE);
    localparam int BW     = (LOG_S > 0) ? LOG_S : 1;
    localparam int K      = SUM_W + 2 * LOG_S;
    localparam int M_W    = K + 1;
    localparam int PROD_W = SUM_W + M_W;

    logic [M_W-1:0]   recip_tab [MAX_SCALE];

    for (genvar g = 0; g < MAX_SCALE; g++)
    begin : g_recip
        localparam longint unsigned AREA  = longint'((g + 1) * (g + 1));
        localparam longint unsigned RECIP = ((64'd1 << K) + AREA - 64'd1) / AREA;
        assign recip_tab[g] = RECIP[M_W-1:0];
    end

    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_red_reg;
    logic [SUM_W-1:0]  s2_green_reg;
    logic [SUM_W-1:0]  s2_blue_reg;
    logic              s2_row_end_reg;
    logic [M_W-1:0]    recip_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              s2_free;
    logic [BW-1:0]     scale_idx;
    logic [PROD_W-1:0] prod_red;
    logic [PROD_W-1:0] prod_green;
    logic [PROD_W-1:0] prod_blue;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign in_ready  = s2_free;
    assign scale_idx = BW'(scale - SW'(1));

    assign prod_red   = PROD_W'(s2_red_reg)   * PROD_W'(recip_reg);
    assign prod_green = PROD_W'(s2_green_reg) * PROD_W'(recip_reg);
    assign prod_blue  = PROD_W'(s2_blue_reg)  * PROD_W'(recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
                s2_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s2_free)
        begin
            s2_red_reg     <= sum_red;
            s2_green_reg   <= sum_green;
            s2_blue_reg    <= sum_blue;
            s2_row_end_reg <= in_row_end;
            recip_reg      <= recip_tab[scale_idx];
        end
        if (s2_valid_reg && out_free)
        begin
            out_data_reg <= {prod_blue[K +: PIX_W], prod_green[K +: PIX_W],
                             prod_red[K +: PIX_W]};
            out_last_reg <= s2_row_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== design/box_average_image_downscale_core.sv =====
// Box-average image downscaler. A pixel that completes a block has its mean
// registered in the accumulator update stage, the divider input stage and the
// output register before it is valid on m_axis. Throughput: one pixel per cycle
// while the mean stage takes each block sum, set by the read-modify-write of
// the column-sum memory, whose read is bypassed from the latest write.
// Reset (rst_n, asynchronous, active low) sets scale 1, width 4096, clears the
// raster counters and empties the pipeline; the sum memory needs no clearing.
module box_average_image_downscale_core
    import boxavg_pkg::*;
#(
    parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter  int MAX_SCALE = DEF_MAX_SCALE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Pixel input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // red [15:0], green [31:16], blue [47:32]
    input  logic                  s_axis_tuser,   // start_of_frame [0]
    // Downscaled pixel output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,   // out_red [15:0], out_green [31:16],
                                                  // out_blue [47:32]
    output logic                  m_axis_tlast,   // row_end
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(MAX_SCALE + 1);
    localparam int SUM_W = PIX_W + 2 * $clog2(MAX_SCALE);

    logic             in_xfer;
    logic             cfg_xfer;
    logic [AW-1:0]    addr;
    pos_flags_t       flags;
    logic [SW-1:0]    scale_eff;
    logic             sum_valid;
    logic             sum_ready;
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic             sum_row_end;

    // Register writes must arrive only while the block is idle; the block does not
    // enforce this. The write channel can always take a transfer.
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    // The position tracker places every input pixel within its block and row:
    // which output column it feeds, whether it opens or closes a block, and
    // whether that block is complete inside the row.
    boxavg_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_xfer),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_xfer),
        .sof       (s_axis_tuser),
        .addr      (addr),
        .flags     (flags),
        .scale_eff (scale_eff)
    );

    // The accumulator keeps one set of channel sums per output column. The read is
    // issued on the input transfer; the registered update stage adds and writes, and
    // holds while a block sum waits. Pixels outside complete blocks never touch the memory.
    boxavg_accum #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_xfer),
        .ready       (s_axis_tready),
        .pixel       (s_axis_tdata),
        .addr        (addr),
        .flags       (flags),
        .sum_valid   (sum_valid),
        .sum_ready   (sum_ready),
        .sum_red     (sum_red),
        .sum_green   (sum_green),
        .sum_blue    (sum_blue),
        .sum_row_end (sum_row_end)
    );

    // Completed block sums are divided by the block area and held in the
    // output register until the downstream side takes the transfer.
    boxavg_div #(
        .MAX_SCALE (MAX_SCALE)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (sum_valid),
        .in_ready      (sum_ready),
        .sum_red       (sum_red),
        .sum_green     (sum_green),
        .sum_blue      (sum_blue),
        .in_row_end    (sum_row_end),
        .scale         (scale_eff),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/box_average_image_downscale_core_tb.sv =====
// Self-checking testbench for box_average_image_downscale_core.
// Drives pixel frames and register writes, predicts every block mean and compares
// it with the output stream. Depends on boxavg_pkg and the core itself.
module box_average_image_downscale_core_tb;

    import boxavg_pkg::*;

    localparam int MAX_W  = DEF_MAX_WIDTH;
    localparam int MAX_SC = DEF_MAX_SCALE;

    // Watchdog in clock cycles. The slowest correct run has about 1300 pixels, in half
    // of the random phases spread out by 79 percent sender idling or receiver stalling.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Stimulus stops once about this many pixels have been queued; the last few
    // are kept for the final over-wide row. Frames are capped in length.
    localparam int ITEM_TARGET      = 1300;
    localparam int FINAL_ROW_PIXELS = 64;
    localparam int FRAME_CAP        = 160;

    // Cycles to let pass after the last expected mean before a register write or
    // the end; the core's pipeline is three stages deep.
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              sof;
    } pixel_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
    } block_mean_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    box_average_image_downscale_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Pixels waiting to be offered, and block means waiting to come out.
    pixel_item_t pending_pixels[$];
    block_mean_t expected_means[$];

    // Idling of both sides, in percent of cycles; changed between phases.
    int send_idle_pct;
    int recv_stall_pct;

    int  error_count;
    int  printed_errors;
    int  queued_pixels;
    int  cycle_count;
    logic pixel_taken;

    // Shadow of the core: register values, raster position and the column sums.
    logic [SCALE_W-1:0] shadow_scale;
    logic [WIDTH_W-1:0] shadow_width;
    int                 col_pos;
    int                 row_blk;
    int                 col_blk;
    int                 out_col;
    int unsigned        red_sum   [MAX_W];
    int unsigned        green_sum [MAX_W];
    int unsigned        blue_sum  [MAX_W];

    // ------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d means still expected",
                     cycle_count, expected_means.size());
            $display("box_average_image_downscale_core_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // A scale of zero behaves as one, anything above the maximum as the maximum.
    function automatic int active_scale();
        if (shadow_scale == 0)
            return 1;
        if (shadow_scale > MAX_SC)
            return MAX_SC;
        return int'(shadow_scale);
    endfunction

    // The same clamping applies to the width.
    function automatic int active_width();
        if (shadow_width == 0)
            return 1;
        if (shadow_width > MAX_W)
            return MAX_W;
        return int'(shadow_width);
    endfunction

    function automatic void clear_position();
        col_pos = 0;
        row_blk = 0;
        col_blk = 0;
        out_col = 0;
    endfunction

    // A write to either real register also rewinds the raster position; any other
    // index leaves everything alone.
    function automatic void track_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] value);
        if (idx == REG_SCALE_FACTOR)
        begin
            shadow_scale = value[SCALE_W-1:0];
            clear_position();
        end
        else if (idx == REG_IMAGE_WIDTH)
        begin
            shadow_width = value[WIDTH_W-1:0];
            clear_position();
        end
    endfunction

    // Folds one accepted pixel into the column sums and queues the block mean when
    // the pixel closes its block.
    function automatic void predict_block_mean(input logic [DATA_W-1:0] data,
                                               input logic sof);
        int          s;
        int          w;
        int          blocks;
        int unsigned area;
        block_mean_t mean;
        s = active_scale();
        w = active_width();
        blocks = w / s;
        if (sof)
            clear_position();
        if (out_col < blocks)
        begin
            if (row_blk == 0 && col_blk == 0)
            begin
                red_sum[out_col]   = data[15:0];
                green_sum[out_col] = data[31:16];
                blue_sum[out_col]  = data[47:32];
            end
            else
            begin
                red_sum[out_col]   += data[15:0];
                green_sum[out_col] += data[31:16];
                blue_sum[out_col]  += data[47:32];
            end
            if (row_blk == s - 1 && col_blk == s - 1)
            begin
                area = s * s;
                mean.red     = PIX_W'(red_sum[out_col] / area);
                mean.green   = PIX_W'(green_sum[out_col] / area);
                mean.blue    = PIX_W'(blue_sum[out_col] / area);
                mean.row_end = (out_col == blocks - 1);
                expected_means.insert(expected_means.size(), mean);
            end
        end
        col_blk++;
        if (col_blk >= s)
        begin
            col_blk = 0;
            out_col++;
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            col_blk = 0;
            out_col = 0;
            row_blk++;
            if (row_blk >= s)
                row_blk = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver. Everything changes at the falling edge so that the core sees stable
    // inputs at the rising edge. A pixel stays on the bus until its transfer.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        pixel_item_t item;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!s_axis_tvalid || pixel_taken)
            begin
                if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.data;
                    s_axis_tuser  <= item.sof;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Samples both streams at the rising edge: a pixel transfer feeds the
    // predictor, an output transfer is checked against the oldest expected mean.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            if (printed_errors < 40)
            begin
                printed_errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        block_mean_t want;
        if (!rst_n)
        begin
            pixel_taken <= 1'b0;
        end
        else
        begin
            pixel_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_means.size() == 0)
                begin
                    error_count++;
                    if (printed_errors < 40)
                    begin
                        printed_errors++;
                        $display("%0t: unexpected output, expected nothing, got %h last %b",
                                 $time, m_axis_tdata, m_axis_tlast);
                    end
                end
                else
                begin
                    want = expected_means.pop_front();
                    check_field("out_red",   want.red,   m_axis_tdata[15:0]);
                    check_field("out_green", want.green, m_axis_tdata[31:16]);
                    check_field("out_blue",  want.blue,  m_axis_tdata[47:32]);
                    check_field("row_end",   PIX_W'(want.row_end), PIX_W'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_block_mean(s_axis_tdata, s_axis_tuser);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                               input logic [PIX_W-1:0] b, input logic sof);
        pixel_item_t item;
        item.data = {b, g, r};
        item.sof  = sof;
        queued_pixels++;
        pending_pixels.insert(pending_pixels.size(), item);
    endtask

    // Channel values lean toward the extremes so that full-scale sums show up often.
    function automatic logic [PIX_W-1:0] pick_level();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel <= 2)
            return '1;
        return PIX_W'($urandom);
    endfunction

    // Holds the sender back until every queued pixel has made its transfer and
    // every expected mean has come out, then lets the pipeline settle.
    task automatic wait_until_drained(input int settle);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_means.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One register write transfer; only called while the core is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        track_register_write(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    // Queues one frame for the current settings. Most frames are whole block rows,
    // some carry an incomplete bottom block row, and a few are cut short or get a
    // stray start-of-frame in the middle.
    task automatic queue_frame();
        int s;
        int w;
        int rows;
        int n_pix;
        logic broken;
        logic sof;
        s = active_scale();
        w = active_width();
        rows = s * $urandom_range(1, 3);
        if ($urandom_range(0, 9) == 0)
            rows += $urandom_range(0, s - 1);
        if (rows * w > FRAME_CAP)
            rows = (FRAME_CAP / w > 0) ? FRAME_CAP / w : 1;
        n_pix = rows * w;
        if (n_pix > FRAME_CAP)
            n_pix = FRAME_CAP;
        broken = ($urandom_range(0, 9) == 0);
        if (broken)
            n_pix = $urandom_range(1, n_pix);
        for (int k = 0; k < n_pix; k++)
        begin
            sof = (k == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
            if (broken && $urandom_range(0, 19) == 0)
                sof = 1'b1;
            queue_pixel(pick_level(), pick_level(), pick_level(), sof);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int n_frames;
        logic [SCALE_W-1:0] new_scale;
        logic [WIDTH_W-1:0] new_width;
        logic [SCALE_W-1:0] first_scales [4];
        logic [WIDTH_W-1:0] first_widths [4];

        first_scales = '{4'd8, 4'd15, 4'd0, 4'd1};
        first_widths = '{13'd16, 13'd9, 13'd0, 13'd1};

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        error_count    = 0;
        printed_errors = 0;
        queued_pixels  = 0;
        cycle_count    = 0;
        pixel_taken    = 1'b0;
        shadow_scale   = RST_SCALE;
        shadow_width   = RST_WIDTH;
        clear_position();
        set_idle_mode(0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Reset settings pass pixels straight through; a start of
        // frame in mid row must rewind the position.
        queue_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
        queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_pixel(16'h8000, 16'h7FFF, 16'h5555, 1'b0);
        queue_pixel(16'hAAAA, 16'h0001, 16'hFFFE, 1'b1);
        wait_until_drained(SETTLE_CYCLES);

        // An unknown index must be ignored; then a zero scale acts as one. The
        // upper data bits are set to show they are dropped.
        write_register(8'hFF, 16'hFFFF);
        write_register(REG_SCALE_FACTOR, 16'hFFF0);
        write_register(REG_IMAGE_WIDTH, 16'hE003);
        for (int k = 0; k < 3; k++)
            queue_pixel(pick_level(), pick_level(), pick_level(), k == 0);
        wait_until_drained(SETTLE_CYCLES);

        // Scale 2 over a row of 5: the fifth column is a right-edge remainder.
        write_register(REG_SCALE_FACTOR, 16'h0002);
        write_register(REG_IMAGE_WIDTH, 16'h0005);
        for (int k = 0; k < 10; k++)
        begin
            if (k % 5 < 2)
                queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, k == 0);
            else
                queue_pixel(pick_level(), pick_level(), pick_level(), 1'b0);
        end
        wait_until_drained(SETTLE_CYCLES);

        // A row narrower than one block never yields anything.
        write_register(REG_IMAGE_WIDTH, 16'h0001);
        for (int k = 0; k < 4; k++)
            queue_pixel(16'hFFFF, 16'h0000, 16'hFFFF, k == 0);
        wait_until_drained(SETTLE_CYCLES);

        // Random phases: the idling mode rotates, the first phases hit the clamped
        // and extreme register values, later ones draw them at random.
        phase = 0;
        while (queued_pixels < ITEM_TARGET - FINAL_ROW_PIXELS && phase < 400)
        begin
            set_idle_mode(phase % 4);
            wait_until_drained(SETTLE_CYCLES);
            if (phase < 4)
            begin
                new_scale = first_scales[phase];
                new_width = first_widths[phase];
            end
            else
            begin
                new_scale = ($urandom_range(0, 9) < 7) ? SCALE_W'($urandom_range(1, MAX_SC))
                                                       : SCALE_W'($urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0: new_width = WIDTH_W'($urandom_range(0, 8191));
                    1: new_width = WIDTH_W'($urandom_range(0, 2));
                    default: new_width = WIDTH_W'($urandom_range(1, 32));
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
            if (phase < 4 || $urandom_range(0, 3) != 0)
                write_register(REG_SCALE_FACTOR,
                               CFG_DATA_W'({CFG_DATA_W'($urandom) >> SCALE_W, new_scale}));
            if (phase < 4 || $urandom_range(0, 3) != 0)
                write_register(REG_IMAGE_WIDTH,
                               CFG_DATA_W'({CFG_DATA_W'($urandom) >> WIDTH_W, new_width}));
            n_frames = $urandom_range(1, 3);
            for (int f = 0; f < n_frames && queued_pixels < ITEM_TARGET - FINAL_ROW_PIXELS;
                 f++)
            begin
                queue_frame();
                // Now and then the sender holds off until the core has emptied.
                if ($urandom_range(0, 6) == 0)
                    wait_until_drained(0);
            end
            phase++;
        end

        // Start of one long row: a width beyond the maximum acts as the maximum,
        // so none of these pass-through pixels closes the row.
        set_idle_mode(3);
        wait_until_drained(SETTLE_CYCLES);
        write_register(REG_SCALE_FACTOR, 16'hFFF1);
        write_register(REG_IMAGE_WIDTH, 16'hFFFF);
        for (int k = 0; k < FINAL_ROW_PIXELS; k++)
            queue_pixel(pick_level(), pick_level(), pick_level(), k == 0);

        wait_until_drained(SETTLE_CYCLES);
        if (error_count == 0)
            $display("box_average_image_downscale_core_tb: clean");
        else
            $display("box_average_image_downscale_core_tb: errors");
        $finish;
    end

endmodule
